### rtl/core/hds_pkg.sv
package hds_pkg;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int TEMP_W    = 32;
    localparam int COEF_W    = 16;
    localparam int PWIDTH_W  = 11;
    localparam int PHEIGHT_W = 16;
    localparam int FRAC_W    = 16;
    localparam int MIN_PAD   = 3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_PADDED_WIDTH  = 2'd0,
        REG_PADDED_HEIGHT = 2'd1,
        REG_COEF_X        = 2'd2,
        REG_COEF_Y        = 2'd3
    } reg_idx_t;

endpackage

### rtl/core/heat_diffusion_stencil_step.sv
// channel  | handshake         | payload
// ---------+-------------------+-------------------------------
// input    | s_valid / s_ready | s_old_temp[31:0], s_grid_start
// result   | m_valid / m_ready | m_new_temp[31:0], m_last_cell
// config   | APB write/read    | paddr[3:0], pwdata, prdata
//
// One item per cycle is accepted while s_ready is high; an interior cell's result goes through
// the line buffer read, window, difference, multiply and sum registers after the edge that
// accepts the item completing its stencil. The line buffers are single-write memories read
// once per item; the forward path has one multiplier per axis, each followed by a register.
// Synchronous active-low reset clears counters, window, and valid bits; line buffers are
// not cleared. A stalled result holds its stage; earlier stages keep filling until full.
module heat_diffusion_stencil_step #(
    parameter int MAX_WIDTH = hds_pkg::DEF_MAX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [hds_pkg::TEMP_W-1:0]   s_old_temp,
    input  logic                                s_grid_start,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [hds_pkg::TEMP_W-1:0]   m_new_temp,
    output logic                                m_last_cell,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hds_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [hds_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [hds_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import hds_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int LW   = (CW + 1 > PWIDTH_W) ? CW + 1 : PWIDTH_W;
    localparam int DW   = TEMP_W + 2;
    localparam int PRW  = DW + COEF_W + 1;
    localparam int SCW  = PRW - FRAC_W;
    localparam int SUMW = SCW + 1;

    // ---------------- configuration ----------------
    logic [PWIDTH_W-1:0]  padded_width_reg;
    logic [PHEIGHT_W-1:0] padded_height_reg;
    logic [COEF_W-1:0]    coef_x_reg;
    logic [COEF_W-1:0]    coef_y_reg;
    reg_idx_t             reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            padded_width_reg  <= PWIDTH_W'(MIN_PAD);
            padded_height_reg <= PHEIGHT_W'(MIN_PAD);
            coef_x_reg        <= '0;
            coef_y_reg        <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PADDED_WIDTH:  padded_width_reg  <= pwdata[PWIDTH_W-1:0];
                REG_PADDED_HEIGHT: padded_height_reg <= pwdata[PHEIGHT_W-1:0];
                REG_COEF_X:        coef_x_reg        <= pwdata[COEF_W-1:0];
                REG_COEF_Y:        coef_y_reg        <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PADDED_WIDTH:  prdata = APB_DATA_W'(padded_width_reg);
            REG_PADDED_HEIGHT: prdata = APB_DATA_W'(padded_height_reg);
            REG_COEF_X:        prdata = APB_DATA_W'(coef_x_reg);
            REG_COEF_Y:        prdata = APB_DATA_W'(coef_y_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- stage handshake ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic ld1, ld2, ld3, ld4, out_free, acc, xfer12;

    assign out_free = !m_valid_reg || m_ready;
    assign ld4      = !v4_reg || out_free;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_ready  = ld1;
    assign acc      = s_valid && s_ready;
    assign xfer12   = v1_reg && ld2;

    // ---------------- raster counters ----------------
    logic [CW-1:0]        col_cnt_reg, col_cnt_next, col_cur;
    logic [PHEIGHT_W-1:0] row_cnt_reg, row_cnt_next, row_cur;
    logic [LW-1:0]        pw_ext, eff_w, col_inc;
    logic [PHEIGHT_W-1:0] eff_h;
    logic [PHEIGHT_W:0]   row_inc;
    logic                 row_end, grid_end, emit;

    always_comb begin
        col_cur = s_grid_start ? '0 : col_cnt_reg;
        row_cur = s_grid_start ? '0 : row_cnt_reg;

        pw_ext = LW'(padded_width_reg);
        if (pw_ext < LW'(MIN_PAD)) begin
            eff_w = LW'(MIN_PAD);
        end else if (pw_ext > LW'(MAX_WIDTH)) begin
            eff_w = LW'(MAX_WIDTH);
        end else begin
            eff_w = pw_ext;
        end
        eff_h = (padded_height_reg < PHEIGHT_W'(MIN_PAD)) ? PHEIGHT_W'(MIN_PAD)
                                                          : padded_height_reg;

        col_inc  = LW'(col_cur) + LW'(1);
        row_inc  = (PHEIGHT_W+1)'(row_cur) + (PHEIGHT_W+1)'(1);
        row_end  = (col_inc >= eff_w);
        grid_end = row_end && (row_inc >= (PHEIGHT_W+1)'(eff_h));
        emit     = (row_cur >= PHEIGHT_W'(2)) && (LW'(col_cur) >= LW'(2));

        if (row_end) begin
            col_cnt_next = '0;
            row_cnt_next = grid_end ? '0 : row_inc[PHEIGHT_W-1:0];
        end else begin
            col_cnt_next = col_inc[CW-1:0];
            row_cnt_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (acc) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------- line buffers (stage 1) ----------------
    logic signed [TEMP_W-1:0] line_above_reg  [MAX_WIDTH];
    logic signed [TEMP_W-1:0] line_center_reg [MAX_WIDTH];
    logic signed [TEMP_W-1:0] abv_rd_reg, ctr_rd_reg, byp_data_reg, abv_eff;
    logic signed [TEMP_W-1:0] s1_temp_reg;
    logic [CW-1:0]            s1_idx_reg;
    logic                     s1_emit_reg, s1_last_reg, byp_hit_reg;

    always_ff @(posedge aclk) begin
        if (acc) begin
            ctr_rd_reg               <= line_center_reg[col_cur];
            line_center_reg[col_cur] <= s_old_temp;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            abv_rd_reg <= line_above_reg[col_cur];
        end
        if (xfer12) begin
            line_above_reg[s1_idx_reg] <= ctr_rd_reg;
        end
    end

    // forward a write that lands on the same edge as the read
    always_ff @(posedge aclk) begin
        if (acc) begin
            byp_hit_reg  <= xfer12 && (s1_idx_reg == col_cur);
            byp_data_reg <= ctr_rd_reg;
            s1_temp_reg  <= s_old_temp;
            s1_idx_reg   <= col_cur;
            s1_emit_reg  <= emit;
            s1_last_reg  <= grid_end;
        end
    end

    assign abv_eff = byp_hit_reg ? byp_data_reg : abv_rd_reg;

    // ---------------- window (stage 2) ----------------
    logic signed [TEMP_W-1:0] win_n1_reg, win_n2_reg;
    logic signed [TEMP_W-1:0] win_c0_reg, win_c1_reg, win_c2_reg;
    logic signed [TEMP_W-1:0] win_s1_reg, win_s2_reg;
    logic                     s2_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_n1_reg <= '0;
            win_n2_reg <= '0;
            win_c0_reg <= '0;
            win_c1_reg <= '0;
            win_c2_reg <= '0;
            win_s1_reg <= '0;
            win_s2_reg <= '0;
        end else if (xfer12) begin
            win_n1_reg <= win_n2_reg;
            win_n2_reg <= abv_eff;
            win_c0_reg <= win_c1_reg;
            win_c1_reg <= win_c2_reg;
            win_c2_reg <= ctr_rd_reg;
            win_s1_reg <= win_s2_reg;
            win_s2_reg <= s1_temp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer12) begin
            s2_last_reg <= s1_last_reg;
        end
    end

    // ---------------- differences (stage 3) ----------------
    logic signed [DW-1:0]     dx_next, dy_next, dx3_reg, dy3_reg;
    logic signed [TEMP_W-1:0] t3_reg;
    logic                     s3_last_reg;

    // north and south sit in the middle column, above and below the center
    always_comb begin
        dx_next = DW'(win_c0_reg) + DW'(win_c2_reg) - (DW'(win_c1_reg) <<< 1);
        dy_next = DW'(win_n1_reg) + DW'(win_s1_reg) - (DW'(win_c1_reg) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && ld3) begin
            dx3_reg     <= dx_next;
            dy3_reg     <= dy_next;
            t3_reg      <= win_c1_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ---------------- products (stage 4) ----------------
    logic signed [COEF_W:0]   cx_s, cy_s;
    logic signed [PRW-1:0]    prod_x, prod_y;
    logic signed [SCW-1:0]    px4_reg, py4_reg;
    logic signed [TEMP_W-1:0] t4_reg;
    logic                     s4_last_reg;

    assign cx_s   = $signed({1'b0, coef_x_reg});
    assign cy_s   = $signed({1'b0, coef_y_reg});
    assign prod_x = PRW'(dx3_reg) * PRW'(cx_s);
    assign prod_y = PRW'(dy3_reg) * PRW'(cy_s);

    always_ff @(posedge aclk) begin
        if (v3_reg && ld4) begin
            // floor of the Q0.16 scale: drop the fraction bits arithmetically
            px4_reg     <= prod_x[PRW-1:FRAC_W];
            py4_reg     <= prod_y[PRW-1:FRAC_W];
            t4_reg      <= t3_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ---------------- sum and saturate (output) ----------------
    localparam logic signed [SUMW-1:0] SAT_MAX = SUMW'({1'b0, {(TEMP_W-1){1'b1}}});
    localparam logic signed [SUMW-1:0] SAT_MIN = -SAT_MAX - SUMW'(1);

    logic signed [SUMW-1:0]   sum;
    logic signed [TEMP_W-1:0] sat_next, m_new_temp_reg;
    logic                     m_last_cell_reg;

    always_comb begin
        sum = SUMW'(t4_reg) + SUMW'(px4_reg) + SUMW'(py4_reg);
        if (sum > SAT_MAX) begin
            sat_next = {1'b0, {(TEMP_W-1){1'b1}}};
        end else if (sum < SAT_MIN) begin
            sat_next = {1'b1, {(TEMP_W-1){1'b0}}};
        end else begin
            sat_next = sum[TEMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (v4_reg && out_free) begin
            m_new_temp_reg  <= sat_next;
            m_last_cell_reg <= s4_last_reg;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= acc;
            // drop items that complete no interior cell
            if (ld2) v2_reg <= v1_reg && s1_emit_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (out_free) m_valid_reg <= v4_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_temp  = m_new_temp_reg;
    assign m_last_cell = m_last_cell_reg;

    // ---------------- assertions ----------------
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid after reset");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && m_valid_reg && !m_ready))
        else $error("input stalled while pipeline has room");

    a_grid_start_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_grid_start) |=> (col_cnt_reg == CW'(1) && row_cnt_reg == '0))
        else $error("grid start did not restart raster counters");

endmodule
